FILE: rtl/pslem_pkg.sv
// shared widths, register indexes, phase and action codes
// and the per-item control struct of the latency average monitor
// no dependencies
package pslem_pkg;

  localparam int SID_W     = 10;
  localparam int TIME_W    = 64;
  localparam int PERIOD_W  = 32;
  localparam int WEIGHT_W  = 33;
  localparam int CFG_W     = 33;
  localparam int CFG_IDX_W = 1;
  localparam int AVG_W     = 64;
  localparam int FRAC_W    = 32;
  localparam int EMIT_W    = 32;
  // wide enough to hold any source count the monitor may be built for
  localparam int EXT_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 32'd1000000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 33'd268435456;
  localparam logic [WEIGHT_W-1:0] Q_ONE      = 33'h1_0000_0000;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_NODE = 2'd1;
  localparam logic [1:0] PH_AVG  = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_PKT  = 2'd1;
  localparam logic [1:0] ACT_NODE = 2'd2;
  localparam logic [1:0] ACT_AVG  = 2'd3;

  typedef struct packed {
    logic [1:0]        act;
    logic              taken;
    logic              ev;
    logic              kind;
    logic [SID_W-1:0]  sid;
    logic [TIME_W-1:0] last;
  } item_t;

endpackage

FILE: rtl/per_source_latency_ema_monitor.sv
// top level of the per-source latency average monitor
// uses pslem_pkg and two pslem_ram instances (average table, connected list)
//
// Every accepted item is one call and yields exactly one result item. An
// item passes through acceptance, stage 1 and stage 2: the acceptance edge
// issues the table read, stage 1 runs the three 33x32 multiplies of the
// average update, and stage 2 writes the entry back and loads the result
// once the output register is free. The input takes no new item until the
// last one has left stage 2, as the read-modify-write of the average table
// needs; items never overlap, so no two accesses to one entry can race. A
// finished result may wait in the output register while the next item is
// accepted. After reset a clearing pass zeroes the average table, one entry
// a cycle, with in_stall held high; configuration writes are taken during
// it.
module per_source_latency_ema_monitor #(
  parameter int NUM_SOURCES = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_measure_enable,
  input  logic                            in_packet_valid,
  input  logic [pslem_pkg::SID_W-1:0]     in_source_id,
  input  logic [pslem_pkg::TIME_W-1:0]    in_sent_time,
  input  logic [pslem_pkg::TIME_W-1:0]    in_now_time,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_packet_taken,
  output logic                            out_emit_valid,
  output logic                            out_emit_kind,
  output logic [pslem_pkg::EMIT_W-1:0]    out_emit_value,
  output logic [pslem_pkg::TIME_W-1:0]    out_last_latency,
  // configuration writes
  input  logic                            cfg_wr_en,
  input  logic [pslem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pslem_pkg::CFG_W-1:0]     cfg_wr_data
);

  import pslem_pkg::*;

  localparam int IDX_W = $clog2(NUM_SOURCES);
  localparam int CNT_W = $clog2(NUM_SOURCES + 1);
  localparam int MEM_W = AVG_W + 1;
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_SOURCES - 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(NUM_SOURCES);
  localparam logic [EXT_W-1:0] SRC_LIMIT = EXT_W'(NUM_SOURCES);

  // configuration registers
  logic [PERIOD_W-1:0] period_r;
  logic [WEIGHT_W-1:0] weight_r;

  // scalar state
  logic [1:0]          phase_r, phase_nxt;
  logic [PERIOD_W-1:0] period_cnt_r, period_cnt_nxt;
  logic [CNT_W-1:0]    active_r, active_nxt;
  logic [IDX_W-1:0]    append_r, append_nxt;
  logic [IDX_W-1:0]    rdptr_r, rdptr_nxt;
  logic [SID_W-1:0]    cur_src_r, cur_src_nxt;
  logic [TIME_W-1:0]   held_r, held_nxt;

  // clearing pass after reset
  logic                clr_busy_r;
  logic [IDX_W-1:0]    clr_addr_r;

  // stage 1: table data is back, multiplies run
  logic                s1_v_r;
  item_t               s1_r;
  logic [FRAC_W-1:0]   lat_r;

  // stage 2: write back and load result
  logic                s2_v_r;
  item_t               s2_r;
  logic [EMIT_W-1:0]   s2_val_r;
  logic [AVG_W-1:0]    p_hi_r;
  logic [FRAC_W-1:0]   p_lo_r;
  logic [AVG_W-1:0]    p_add_r;
  logic [AVG_W-1:0]    avg_hold_r;

  // result register
  logic                out_valid_r;
  logic                out_taken_r;
  logic                out_ev_r;
  logic                out_kind_r;
  logic [EMIT_W-1:0]   out_value_r;
  logic [TIME_W-1:0]   out_last_r;

  logic                accept;
  logic                out_free;
  logic                s2_done;
  item_t               acc_item;
  logic [TIME_W-1:0]   lat;
  logic [EXT_W-1:0]    sid_ext;
  logic [EXT_W-1:0]    cur_ext;
  logic                sid_in_range;
  logic [CNT_W-1:0]    active_dec;
  logic [IDX_W-1:0]    rdptr_inc;
  logic [IDX_W-1:0]    append_inc;

  // table ports
  logic                avg_wr_en;
  logic [IDX_W-1:0]    avg_wr_addr;
  logic [MEM_W-1:0]    avg_wr_data;
  logic                avg_rd_en;
  logic [IDX_W-1:0]    avg_rd_addr;
  logic [MEM_W-1:0]    avg_rd_data;
  logic                list_wr_en;
  logic                list_rd_en;
  logic [SID_W-1:0]    list_rd_data;

  // stage 1 arithmetic
  logic [WEIGHT_W-1:0] beta;
  logic [WEIGHT_W-1:0] keep_w;
  logic [64:0]         prod_hi;
  logic [64:0]         prod_lo;
  logic [64:0]         prod_add;
  logic                s1_conn;
  logic                s1_new_src;
  logic [AVG_W-1:0]    new_avg;

  // handshake: one item in flight at a time, output register decoupled
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = clr_busy_r || s1_v_r || s2_v_r;
  assign accept   = in_valid && !in_stall;
  assign s2_done  = s2_v_r && out_free;

  // absolute time difference
  assign lat = (in_sent_time >= in_now_time) ? (in_sent_time - in_now_time)
                                             : (in_now_time - in_sent_time);

  assign sid_ext      = EXT_W'(in_source_id);
  assign cur_ext      = EXT_W'(cur_src_r);
  assign sid_in_range = sid_ext < SRC_LIMIT;
  assign active_dec   = (active_r != '0) ? (active_r - 1'b1) : active_r;
  assign rdptr_inc    = (rdptr_r == IDX_LAST) ? '0 : (rdptr_r + 1'b1);
  assign append_inc   = (append_r == IDX_LAST) ? '0 : (append_r + 1'b1);

  // first packet from a source appends it to the connected list
  assign s1_conn    = avg_rd_data[AVG_W];
  assign s1_new_src = s1_v_r && (s1_r.act == ACT_PKT) && !s1_conn;

  // decision for the call at acceptance, list append from stage 1
  always_comb begin
    acc_item       = '0;
    acc_item.act   = ACT_NONE;
    acc_item.sid   = in_source_id;
    acc_item.last  = held_r;
    phase_nxt      = phase_r;
    period_cnt_nxt = period_cnt_r;
    active_nxt     = active_r;
    append_nxt     = append_r;
    rdptr_nxt      = rdptr_r;
    held_nxt       = held_r;
    cur_src_nxt    = cur_src_r;
    case (phase_r)
      PH_NODE: begin
        // first readout word: source id from the list
        acc_item.act   = ACT_NODE;
        acc_item.ev    = 1'b1;
        period_cnt_nxt = period_cnt_r + 1'b1;
        phase_nxt      = PH_AVG;
      end
      PH_AVG: begin
        // second readout word: average, clears the connected mark
        acc_item.act   = ACT_AVG;
        acc_item.ev    = 1'b1;
        acc_item.kind  = 1'b1;
        period_cnt_nxt = period_cnt_r + 1'b1;
        rdptr_nxt      = rdptr_inc;
        active_nxt     = active_dec;
        phase_nxt      = (active_dec == '0) ? PH_IDLE : PH_NODE;
      end
      default: begin
        rdptr_nxt = '0;
        if (!in_measure_enable) begin
          period_cnt_nxt = '0;
        end else if (period_cnt_r == period_r) begin
          // period reached: start a readout if any source is listed
          period_cnt_nxt = '0;
          append_nxt     = '0;
          phase_nxt      = (active_r == '0) ? PH_IDLE : PH_NODE;
        end else begin
          period_cnt_nxt = period_cnt_r + 1'b1;
          if (in_packet_valid) begin
            acc_item.taken = 1'b1;
            held_nxt       = lat;
            // out-of-range sources touch no table
            if (sid_in_range) begin
              acc_item.act = ACT_PKT;
            end
          end
        end
      end
    endcase
    // count and append pointer move with a call only when it is accepted
    if (!accept) begin
      active_nxt = active_r;
      append_nxt = append_r;
    end
    if (s1_new_src) begin
      append_nxt = append_inc;
      if (active_r < CNT_MAX) begin
        active_nxt = active_r + 1'b1;
      end
    end
    if (s1_v_r && (s1_r.act == ACT_NODE)) begin
      cur_src_nxt = list_rd_data;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      weight_r <= WEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PERIOD: period_r <= cfg_wr_data[PERIOD_W-1:0];
        REG_WEIGHT: weight_r <= cfg_wr_data[WEIGHT_W-1:0];
        default:    period_r <= period_r;
      endcase
    end
  end

  // scalar state and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      period_cnt_r <= '0;
      active_r     <= '0;
      append_r     <= '0;
      rdptr_r      <= '0;
      cur_src_r    <= '0;
      held_r       <= '0;
      clr_busy_r   <= 1'b1;
      clr_addr_r   <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        phase_r      <= phase_nxt;
        period_cnt_r <= period_cnt_nxt;
        rdptr_r      <= rdptr_nxt;
        held_r       <= held_nxt;
      end
      active_r  <= active_nxt;
      append_r  <= append_nxt;
      cur_src_r <= cur_src_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == IDX_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
      s1_v_r      <= accept;
      s2_v_r      <= s1_v_r || (s2_v_r && !out_free);
      out_valid_r <= s2_done || (out_valid_r && out_stall);
    end
  end

  // average update: (1-beta)*avg + beta*lat, weight saturated at one
  assign beta     = (weight_r > Q_ONE) ? Q_ONE : weight_r;
  assign keep_w   = Q_ONE - beta;
  assign prod_hi  = 65'(keep_w) * 65'(avg_rd_data[AVG_W-1:FRAC_W]);
  assign prod_lo  = 65'(keep_w) * 65'(avg_rd_data[FRAC_W-1:0]);
  assign prod_add = 65'(beta) * 65'(lat_r);
  assign new_avg  = p_hi_r + AVG_W'(p_lo_r) + p_add_r;

  // payload pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r  <= acc_item;
      lat_r <= lat[FRAC_W-1:0];
    end
    if (s1_v_r) begin
      s2_r       <= s1_r;
      p_hi_r     <= prod_hi[AVG_W-1:0];
      p_lo_r     <= prod_lo[AVG_W-1:FRAC_W];
      p_add_r    <= prod_add[AVG_W-1:0];
      avg_hold_r <= avg_rd_data[AVG_W-1:0];
      case (s1_r.act)
        ACT_NODE: s2_val_r <= EMIT_W'(list_rd_data);
        ACT_AVG:  s2_val_r <= avg_rd_data[AVG_W-1:FRAC_W];
        default:  s2_val_r <= '0;
      endcase
    end
    if (s2_done) begin
      out_taken_r <= s2_r.taken;
      out_ev_r    <= s2_r.ev;
      out_kind_r  <= s2_r.kind;
      out_value_r <= s2_val_r;
      out_last_r  <= s2_r.last;
    end
  end

  // average table: {connected, Q32.32 average}
  assign avg_rd_en   = accept && ((acc_item.act == ACT_PKT) || (acc_item.act == ACT_AVG));
  assign avg_rd_addr = (acc_item.act == ACT_PKT) ? sid_ext[IDX_W-1:0] : cur_ext[IDX_W-1:0];

  always_comb begin
    avg_wr_en   = 1'b0;
    avg_wr_addr = IDX_W'(s2_r.sid);
    avg_wr_data = '0;
    if (clr_busy_r) begin
      avg_wr_en   = 1'b1;
      avg_wr_addr = clr_addr_r;
    end else if (s2_done) begin
      case (s2_r.act)
        ACT_PKT: begin
          avg_wr_en   = 1'b1;
          avg_wr_addr = IDX_W'(s2_r.sid);
          avg_wr_data = {1'b1, new_avg};
        end
        ACT_AVG: begin
          avg_wr_en   = 1'b1;
          avg_wr_addr = cur_ext[IDX_W-1:0];
          avg_wr_data = {1'b0, avg_hold_r};
        end
        default: avg_wr_en = 1'b0;
      endcase
    end
  end

  pslem_ram #(
    .WIDTH (MEM_W),
    .DEPTH (NUM_SOURCES)
  ) u_avg_ram (
    .clk     (clk),
    .wr_en   (avg_wr_en),
    .wr_addr (avg_wr_addr),
    .wr_data (avg_wr_data),
    .rd_en   (avg_rd_en),
    .rd_addr (avg_rd_addr),
    .rd_data (avg_rd_data)
  );

  // connected list: appended from stage 1, read during readout
  assign list_wr_en = s1_new_src;
  assign list_rd_en = accept && (acc_item.act == ACT_NODE);

  pslem_ram #(
    .WIDTH (SID_W),
    .DEPTH (NUM_SOURCES)
  ) u_list_ram (
    .clk     (clk),
    .wr_en   (list_wr_en),
    .wr_addr (append_r),
    .wr_data (s1_r.sid),
    .rd_en   (list_rd_en),
    .rd_addr (rdptr_r),
    .rd_data (list_rd_data)
  );

  assign out_valid        = out_valid_r;
  assign out_packet_taken = out_taken_r;
  assign out_emit_valid   = out_ev_r;
  assign out_emit_kind    = out_kind_r;
  assign out_emit_value   = out_value_r;
  assign out_last_latency = out_last_r;

endmodule

FILE: rtl/pslem_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module pslem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/pslem_checker.sv
// port-level checks of the latency average monitor and their bind
// uses pslem_pkg; attaches to per_source_latency_ema_monitor
module pslem_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_packet_taken,
  input logic                            out_emit_valid,
  input logic                            out_emit_kind,
  input logic [pslem_pkg::EMIT_W-1:0]    out_emit_value
);

  import pslem_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // a call either takes a packet or emits a word, never both
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_packet_taken && out_emit_valid))
    else $error("packet taken during readout");

  // idle words carry zero kind and value
  a_quiet_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_emit_valid |-> !out_emit_kind && (out_emit_value == '0))
    else $error("stray readout payload");

  // readout words alternate: id word then average word
  a_pairing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_emit_valid && !out_emit_kind
    |=> !in_valid || in_stall || !out_valid || out_stall || !out_emit_valid
        || out_emit_kind || !$past(in_valid && !in_stall))
    else $error("id word not followed by average word");

endmodule

bind per_source_latency_ema_monitor pslem_checker u_pslem_checker (.*);
